>>> rtl/qcp_pkg.sv
// qcp_pkg: types and constants for the quad centroid and plane pipeline
// holds the input and result beat structs and the stage sideband struct
// no dependencies
package qcp_pkg;

    localparam int CW        = 32;  // corner and result field width
    localparam int NORM_FRAC = 30;  // fraction bits of the unit normal
    localparam int SQ_STEPS  = 32;  // one root bit per sqrt stage
    localparam int DIV_STEPS = 31;  // one quotient bit per divide stage

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
        logic signed [CW-1:0] d_x;
        logic signed [CW-1:0] d_y;
        logic signed [CW-1:0] d_z;
    } t_quad_in;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic signed [CW-1:0] normal_x;
        logic signed [CW-1:0] normal_y;
        logic signed [CW-1:0] normal_z;
        logic signed [CW-1:0] plane_offset;
        logic                 degenerate;
        logic                 offset_saturated;
    } t_plane_out;

    // data that rides along the pipeline next to the math
    typedef struct packed {
        logic [2:0][CW-1:0] cen;
        logic [2:0][CW-1:0] a;
        logic [2:0]         neg;
        logic               degen;
    } t_side;

endpackage

>>> rtl/quad_center_and_plane.sv
// quad_center_and_plane: centroid, unit normal and offset of a 3d quad
// depends on qcp_pkg for the beat structs, sideband struct and step counts
//
// Fully pipelined: a quad is accepted in every cycle that i_start is high
// (o_busy is always low), and its result appears on o_plane with o_done
// high for one cycle. Most of the pipeline depth comes from the 32-stage
// square root pipeline and the 31-stage divider pipelines (one result
// bit per stage) that scale the cross product to unit length. Results
// leave in the order the quads came in; the receiver must take every
// beat in the cycle it is shown.
module quad_center_and_plane
    import qcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_quad_in   i_quad,
    output logic       o_busy,
    output logic       o_done,
    output t_plane_out o_plane
);

    logic accept;
    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // ---------------- stage 1: corner sums and edge vectors
    logic                r1_vld;
    t_side               r1_side;
    logic signed [32:0]  r1_u [3];
    logic signed [32:0]  r1_w [3];

    logic signed [31:0]  in_a [3];
    logic signed [31:0]  in_b [3];
    logic signed [31:0]  in_c [3];
    logic signed [31:0]  in_d [3];
    logic signed [33:0]  csum [3];
    t_side               n_side1;

    always_comb begin
        in_a[0] = i_quad.a_x; in_a[1] = i_quad.a_y; in_a[2] = i_quad.a_z;
        in_b[0] = i_quad.b_x; in_b[1] = i_quad.b_y; in_b[2] = i_quad.b_z;
        in_c[0] = i_quad.c_x; in_c[1] = i_quad.c_y; in_c[2] = i_quad.c_z;
        in_d[0] = i_quad.d_x; in_d[1] = i_quad.d_y; in_d[2] = i_quad.d_z;
        n_side1 = '0;
        for (int i = 0; i < 3; i++) begin
            csum[i] = 34'(in_a[i]) + 34'(in_b[i]) + 34'(in_c[i]) + 34'(in_d[i]);
            // floor of sum over four
            n_side1.cen[i] = csum[i][33:2];
            n_side1.a[i]   = in_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
        r1_side <= n_side1;
        for (int i = 0; i < 3; i++) begin
            r1_u[i] <= 33'(in_b[i]) - 33'(in_a[i]);
            r1_w[i] <= 33'(in_d[i]) - 33'(in_a[i]);
        end
    end

    // ---------------- stage 2: six partial products of the cross product
    logic                r2_vld;
    t_side               r2_side;
    logic signed [65:0]  r2_p [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_side <= r1_side;
        r2_p[0] <= 66'(r1_u[1]) * 66'(r1_w[2]);
        r2_p[1] <= 66'(r1_u[2]) * 66'(r1_w[1]);
        r2_p[2] <= 66'(r1_u[2]) * 66'(r1_w[0]);
        r2_p[3] <= 66'(r1_u[0]) * 66'(r1_w[2]);
        r2_p[4] <= 66'(r1_u[0]) * 66'(r1_w[1]);
        r2_p[5] <= 66'(r1_u[1]) * 66'(r1_w[0]);
    end

    // ---------------- stage 3: cross product components
    logic                r3_vld;
    t_side               r3_side;
    logic signed [66:0]  r3_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_side <= r2_side;
        for (int i = 0; i < 3; i++) begin
            r3_n[i] <= 67'(r2_p[2*i]) - 67'(r2_p[2*i+1]);
        end
    end

    // ---------------- stage 4: sign and magnitude
    logic                r4_vld;
    t_side               r4_side;
    logic [64:0]         r4_mag [3];
    logic signed [66:0]  abs_n [3];
    t_side               n_side4;

    always_comb begin
        n_side4 = r3_side;
        for (int i = 0; i < 3; i++) begin
            abs_n[i]       = r3_n[i][66] ? -r3_n[i] : r3_n[i];
            n_side4.neg[i] = r3_n[i][66];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_side <= n_side4;
        for (int i = 0; i < 3; i++) begin
            r4_mag[i] <= abs_n[i][64:0];
        end
    end

    // ---------------- stage 5: bit length of the largest component
    logic                r5_vld;
    t_side               r5_side;
    logic [64:0]         r5_mag [3];
    logic [6:0]          r5_len;
    logic [64:0]         mag_or;
    logic [6:0]          n_len;
    t_side               n_side5;

    always_comb begin
        mag_or = r4_mag[0] | r4_mag[1] | r4_mag[2];
        n_len  = '0;
        for (int b = 0; b < 65; b++) begin
            if (mag_or[b]) begin
                n_len = 7'(b + 1);
            end
        end
        n_side5       = r4_side;
        n_side5.degen = (mag_or == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_side <= n_side5;
        r5_len  <= n_len;
        for (int i = 0; i < 3; i++) begin
            r5_mag[i] <= r4_mag[i];
        end
    end

    // ---------------- stage 6: common scale so the largest sits in [2^30, 2^31)
    logic                r6_vld;
    t_side               r6_side;
    logic [30:0]         r6_s [3];
    logic [95:0]         scl [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            scl[i] = {r5_mag[i], 31'b0} >> r5_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_side <= r5_side;
        for (int i = 0; i < 3; i++) begin
            r6_s[i] <= scl[i][30:0];
        end
    end

    // ---------------- stage 7: squares
    logic                r7_vld;
    t_side               r7_side;
    logic [30:0]         r7_s [3];
    logic [61:0]         r7_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        r7_side <= r6_side;
        for (int i = 0; i < 3; i++) begin
            r7_s[i]  <= r6_s[i];
            r7_sq[i] <= 62'(r6_s[i]) * 62'(r6_s[i]);
        end
    end

    // ---------------- square root pipeline, stage 0 holds the sum of squares
    logic                r_sq_vld  [SQ_STEPS+1];
    t_side               r_sq_side [SQ_STEPS+1];
    logic [2:0][30:0]    r_sq_s    [SQ_STEPS+1];
    logic [63:0]         r_sq_x    [SQ_STEPS+1];
    logic [33:0]         r_sq_rem  [SQ_STEPS+1];
    logic [31:0]         r_sq_root [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_sq_vld[0] <= r7_vld;
        end
        r_sq_side[0] <= r7_side;
        r_sq_s[0]    <= {r7_s[2], r7_s[1], r7_s[0]};
        r_sq_x[0]    <= 64'(r7_sq[0]) + 64'(r7_sq[1]) + 64'(r7_sq[2]);
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        logic [33:0] rem_sh;
        logic [33:0] trial;
        logic        take;

        assign rem_sh = {r_sq_rem[j][31:0], r_sq_x[j][63:62]};
        assign trial  = {r_sq_root[j], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[j+1] <= 1'b0;
            end else begin
                r_sq_vld[j+1] <= r_sq_vld[j];
            end
            r_sq_side[j+1] <= r_sq_side[j];
            r_sq_s[j+1]    <= r_sq_s[j];
            r_sq_x[j+1]    <= {r_sq_x[j][61:0], 2'b00};
            r_sq_rem[j+1]  <= take ? rem_sh - trial : rem_sh;
            r_sq_root[j+1] <= {r_sq_root[j][30:0], take};
        end
    end

    // ---------------- divider pipelines, three lanes sharing the root
    logic                r_dv_vld  [DIV_STEPS+1];
    t_side               r_dv_side [DIV_STEPS+1];
    logic [31:0]         r_dv_r    [DIV_STEPS+1];
    logic [2:0][32:0]    r_dv_rem  [DIV_STEPS+1];
    logic [2:0][30:0]    r_dv_q    [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_sq_vld[SQ_STEPS];
        end
        r_dv_side[0] <= r_sq_side[SQ_STEPS];
        r_dv_r[0]    <= r_sq_root[SQ_STEPS];
        for (int i = 0; i < 3; i++) begin
            r_dv_rem[0][i] <= 33'(r_sq_s[SQ_STEPS][i]);
        end
        r_dv_q[0] <= '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [2:0][32:0] rt;
        logic [2:0]       ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                // first step compares the scaled value itself, the rest shift in zeros
                rt[i] = (k == 0) ? r_dv_rem[k][i] : {r_dv_rem[k][i][31:0], 1'b0};
                ge[i] = (rt[i] >= {1'b0, r_dv_r[k]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
            r_dv_side[k+1] <= r_dv_side[k];
            r_dv_r[k+1]    <= r_dv_r[k];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[k+1][i] <= ge[i] ? rt[i] - {1'b0, r_dv_r[k]} : rt[i];
                r_dv_q[k+1][i]   <= {r_dv_q[k][i][29:0], ge[i]};
            end
        end
    end

    // ---------------- signed normal
    logic                rn_vld;
    t_side               rn_side;
    logic signed [31:0]  rn_nv [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_vld <= 1'b0;
        end else begin
            rn_vld <= r_dv_vld[DIV_STEPS];
        end
        rn_side <= r_dv_side[DIV_STEPS];
        for (int i = 0; i < 3; i++) begin
            if (r_dv_side[DIV_STEPS].degen) begin
                rn_nv[i] <= '0;
            end else if (r_dv_side[DIV_STEPS].neg[i]) begin
                rn_nv[i] <= -32'(r_dv_q[DIV_STEPS][i]);
            end else begin
                rn_nv[i] <= 32'(r_dv_q[DIV_STEPS][i]);
            end
        end
    end

    // ---------------- normal times corner 0
    logic                rp_vld;
    t_side               rp_side;
    logic signed [31:0]  rp_nv [3];
    logic signed [63:0]  rp_prod [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_vld <= 1'b0;
        end else begin
            rp_vld <= rn_vld;
        end
        rp_side <= rn_side;
        for (int i = 0; i < 3; i++) begin
            rp_nv[i]   <= rn_nv[i];
            rp_prod[i] <= 64'(rn_nv[i]) * 64'($signed(rn_side.a[i]));
        end
    end

    // ---------------- dot product sum
    logic                ra_vld;
    t_side               ra_side;
    logic signed [31:0]  ra_nv [3];
    logic signed [63:0]  ra_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
        end else begin
            ra_vld <= rp_vld;
        end
        ra_side <= rp_side;
        ra_dot  <= rp_prod[0] + rp_prod[1] + rp_prod[2];
        for (int i = 0; i < 3; i++) begin
            ra_nv[i] <= rp_nv[i];
        end
    end

    // ---------------- output beat: offset floor shift and saturation
    logic signed [33:0]  off_w;
    logic                sat_hi;
    logic                sat_lo;
    t_plane_out          n_plane;
    logic                r_done;
    t_plane_out          r_plane;

    always_comb begin
        off_w  = 34'(ra_dot >>> NORM_FRAC);
        sat_hi = (off_w > 34'sh0_7FFF_FFFF);
        sat_lo = (off_w < -34'sh0_8000_0000);
        n_plane.center_x   = $signed(ra_side.cen[0]);
        n_plane.center_y   = $signed(ra_side.cen[1]);
        n_plane.center_z   = $signed(ra_side.cen[2]);
        n_plane.normal_x   = ra_nv[0];
        n_plane.normal_y   = ra_nv[1];
        n_plane.normal_z   = ra_nv[2];
        n_plane.degenerate = ra_side.degen;
        n_plane.offset_saturated = sat_hi | sat_lo;
        if (sat_hi) begin
            n_plane.plane_offset = 32'sh7FFF_FFFF;
        end else if (sat_lo) begin
            n_plane.plane_offset = 32'sh8000_0000;
        end else begin
            n_plane.plane_offset = off_w[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ra_vld;
        end
        r_plane <= n_plane;
    end

    assign o_done  = r_done;
    assign o_plane = r_plane;

endmodule
